// ===== rtl/dq_pkg.sv =====
package dq_pkg;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);

  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [CNT_W-1:0]      count_t;
  typedef logic [31:0]           word_t;
  typedef logic [4:0]            count_field_t;

  typedef enum logic [2:0] {
    ACT_NONE       = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_PUSH_FRONT = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_POP_FRONT  = 3'd4,
    ACT_CLEAR      = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_PUSH_FULL = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] push_value;
  } in_t;

  typedef struct packed {
    logic [31:0] front_value;
    logic [31:0] back_value;
    logic [4:0]  entry_count;
    logic        is_empty;
    logic        is_full;
    logic [1:0]  status;
  } result_t;

  // Effective operation broadcast to every cell; at most one bit is set.
  typedef struct packed {
    logic add_front;
    logic add_back;
    logic drop_front;
    logic drop_back;
    logic clear;
  } cell_cmd_t;

endpackage

// ===== rtl/dq_cell.sv =====
module dq_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dq_pkg::cell_cmd_t cmd_i,
  input  dq_pkg::data_t     push_data_i,
  input  dq_pkg::data_t     left_data_i,
  input  logic              left_occ_i,
  input  dq_pkg::data_t     right_data_i,
  input  logic              right_occ_i,
  output dq_pkg::data_t     data_o,
  output logic              occ_o,
  output dq_pkg::data_t     tail_data_o
);

  dq_pkg::data_t data_q, data_d;
  logic          occ_q, occ_d;
  logic          is_tail;

  // The tail cell is the last occupied one in the row.
  assign is_tail = occ_q & ~right_occ_i;

  always_comb begin
    data_d = data_q;
    occ_d  = occ_q;
    if (cmd_i.clear) begin
      occ_d = 1'b0;
    end else if (cmd_i.add_front) begin
      data_d = left_data_i;
      occ_d  = left_occ_i;
    end else if (cmd_i.add_back) begin
      if (left_occ_i && !occ_q) begin
        data_d = push_data_i;
        occ_d  = 1'b1;
      end
    end else if (cmd_i.drop_front) begin
      data_d = right_data_i;
      occ_d  = right_occ_i;
    end else if (cmd_i.drop_back) begin
      if (is_tail) begin
        occ_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o      = data_q;
  assign occ_o       = occ_q;
  assign tail_data_o = is_tail ? data_q : '0;

endmodule

// ===== rtl/double_ended_queue_core.sv =====
// Each command's result strobe comes in the cycle after start.
// busy stays low, so a new beat may be started in every cycle.
// The entries live in a row of cells that shift back on a front push and forward
// on a front pop; a back pop clears the tail cell, a back push fills the next one.
// Reset empties the queue; cell data is not reset and never read while unoccupied.
// The receiver cannot stall, so each result is on the ports for one cycle only.
module double_ended_queue_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  dq_pkg::in_t     in_i,
  output logic            result_valid_o,
  output dq_pkg::result_t result_o
);

  logic              accept;
  logic              full, empty;
  logic              is_push, is_pop;
  dq_pkg::cell_cmd_t cmd;
  dq_pkg::data_t     push_data;
  dq_pkg::count_t    count_q, count_d;
  dq_pkg::status_e   status_q, status_d;
  logic              valid_q;
  dq_pkg::data_t     back_data;

  dq_pkg::data_t cell_data [dq_pkg::DEPTH];
  dq_pkg::data_t cell_tail [dq_pkg::DEPTH];
  logic          cell_occ  [dq_pkg::DEPTH];

  assign busy      = 1'b0;
  assign accept    = start & ~busy;
  assign full      = cell_occ[dq_pkg::DEPTH-1];
  assign empty     = ~cell_occ[0];
  assign push_data = dq_pkg::data_t'(in_i.push_value);

  always_comb begin
    cmd      = '0;
    count_d  = count_q;
    status_d = dq_pkg::ST_OK;
    is_push  = in_i.action inside {dq_pkg::ACT_PUSH_BACK, dq_pkg::ACT_PUSH_FRONT};
    is_pop   = in_i.action inside {dq_pkg::ACT_POP_BACK, dq_pkg::ACT_POP_FRONT};
    if (accept) begin
      if (is_push && full) begin
        status_d = dq_pkg::ST_PUSH_FULL;
      end else if (is_pop && empty) begin
        status_d = dq_pkg::ST_POP_EMPTY;
      end else begin
        case (in_i.action)
          dq_pkg::ACT_PUSH_BACK: begin
            cmd.add_back = 1'b1;
            count_d      = count_q + dq_pkg::count_t'(1);
          end
          dq_pkg::ACT_PUSH_FRONT: begin
            cmd.add_front = 1'b1;
            count_d       = count_q + dq_pkg::count_t'(1);
          end
          dq_pkg::ACT_POP_BACK: begin
            cmd.drop_back = 1'b1;
            count_d       = count_q - dq_pkg::count_t'(1);
          end
          dq_pkg::ACT_POP_FRONT: begin
            cmd.drop_front = 1'b1;
            count_d        = count_q - dq_pkg::count_t'(1);
          end
          dq_pkg::ACT_CLEAR: begin
            cmd.clear = 1'b1;
            count_d   = '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  for (genvar i = 0; i < dq_pkg::DEPTH; i++) begin : g_cell
    dq_pkg::data_t left_data, right_data;
    logic          left_occ, right_occ;

    if (i == 0) begin : g_head
      // The head cell sees the incoming value as its left neighbor.
      assign left_data = push_data;
      assign left_occ  = 1'b1;
    end else begin : g_mid
      assign left_data = cell_data[i-1];
      assign left_occ  = cell_occ[i-1];
    end

    if (i == dq_pkg::DEPTH - 1) begin : g_last
      assign right_data = cell_data[i];
      assign right_occ  = 1'b0;
    end else begin : g_inner
      assign right_data = cell_data[i+1];
      assign right_occ  = cell_occ[i+1];
    end

    dq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .push_data_i  (push_data),
      .left_data_i  (left_data),
      .left_occ_i   (left_occ),
      .right_data_i (right_data),
      .right_occ_i  (right_occ),
      .data_o       (cell_data[i]),
      .occ_o        (cell_occ[i]),
      .tail_data_o  (cell_tail[i])
    );
  end

  // Only the tail cell drives a nonzero value, so an OR picks the back entry.
  always_comb begin
    back_data = '0;
    for (int i = 0; i < dq_pkg::DEPTH; i++) begin
      back_data = back_data | cell_tail[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      status_q <= dq_pkg::ST_OK;
      valid_q  <= 1'b0;
    end else begin
      count_q  <= count_d;
      status_q <= status_d;
      valid_q  <= accept;
    end
  end

  assign result_valid_o       = valid_q;
  assign result_o.front_value = cell_occ[0] ? dq_pkg::word_t'(cell_data[0]) : '0;
  assign result_o.back_value  = dq_pkg::word_t'(back_data);
  assign result_o.entry_count = dq_pkg::count_field_t'(count_q);
  assign result_o.is_empty    = empty;
  assign result_o.is_full     = full;
  assign result_o.status      = status_q;

endmodule
